// ----- src/irf_pkg.sv -----
// Shared types and constants for the IPv4 receive filter.
package irf_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] MIN_HDR_BYTES = 6'd20;
  localparam logic [3:0] IP_VERSION    = 4'd4;
  localparam logic [3:0] MIN_IHL       = 4'd5;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;
  localparam logic [15:0] CSUM_OK     = 16'hFFFF;

  // Header byte offsets
  localparam logic [15:0] OFS_VER_IHL = 16'd0;
  localparam logic [15:0] OFS_TLEN_HI = 16'd2;
  localparam logic [15:0] OFS_TLEN_LO = 16'd3;
  localparam logic [15:0] OFS_PROTO   = 16'd9;
  localparam logic [15:0] OFS_SRC0    = 16'd12;
  localparam logic [15:0] OFS_SRC3    = 16'd15;
  localparam logic [15:0] OFS_DST0    = 16'd16;
  localparam logic [15:0] OFS_DST3    = 16'd19;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_DROP    = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    DROP_SHORT    = 3'd0,
    DROP_VERSION  = 3'd1,
    DROP_LENGTH   = 3'd2,
    DROP_HDR_LEN  = 3'd3,
    DROP_CHECKSUM = 3'd4,
    DROP_NOT_OURS = 3'd5
  } drop_reason_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_len;
    logic        frame_end;
  } irf_in_t;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   payload_byte;
    logic [7:0]   protocol;
    logic [31:0]  source_ip;
    logic         payload_last;
    drop_reason_e drop_reason;
  } irf_out_t;

endpackage

// ----- src/irf_front.sv -----
// Front end: byte intake, header parse and checks, result classification.
module irf_front
  import irf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  irf_in_t  in_data_i,
  input  logic     q_full_i,
  output logic     push_o,
  output irf_out_t push_data_o
);

  logic [31:0]  local_ip_q;
  logic [15:0]  pos_q, pos_d;
  logic [5:0]   hdr_len_q, hdr_len_d;
  logic [15:0]  total_len_q, total_len_d;
  logic [15:0]  csum_q, csum_d;
  logic [7:0]   hi_byte_q, hi_byte_d;
  logic [7:0]   proto_q, proto_d;
  logic [31:0]  src_q, src_d;
  logic [31:0]  dst_q, dst_d;
  logic         drop_q, drop_d;
  drop_reason_e code_q, code_d;

  logic         accept;
  logic         emit;
  irf_out_t     res;
  logic [7:0]   b;
  logic [16:0]  csum_sum;
  logic [15:0]  csum_fold;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign b          = in_data_i.data_byte;

  // End-around-carry add of the current 16-bit word
  assign csum_sum  = {1'b0, csum_q} + {1'b0, hi_byte_q, b};
  assign csum_fold = csum_sum[15:0] + {15'd0, csum_sum[16]};

  always_comb begin
    pos_d       = pos_q;
    hdr_len_d   = hdr_len_q;
    total_len_d = total_len_q;
    csum_d      = csum_q;
    hi_byte_d   = hi_byte_q;
    proto_d     = proto_q;
    src_d       = src_q;
    dst_d       = dst_q;
    drop_d      = drop_q;
    code_d      = code_q;
    emit        = 1'b0;
    res         = '0;

    if (accept) begin
      if (pos_q < {10'd0, hdr_len_q}) begin
        if (pos_q == OFS_VER_IHL) begin
          priority if (in_data_i.frame_len < {10'd0, MIN_HDR_BYTES}) begin
            drop_d = 1'b1;
            code_d = DROP_SHORT;
          end else if (b[7:4] != IP_VERSION) begin
            drop_d = 1'b1;
            code_d = DROP_VERSION;
          end else if (b[3:0] < MIN_IHL) begin
            drop_d = 1'b1;
            code_d = DROP_HDR_LEN;
          end else begin
            hdr_len_d = {b[3:0], 2'b00};
          end
        end else if (pos_q == OFS_TLEN_HI) begin
          total_len_d = {b, 8'd0};
        end else if (pos_q == OFS_TLEN_LO) begin
          total_len_d = {total_len_q[15:8], b};
          if (!drop_d && (total_len_d > in_data_i.frame_len ||
                          total_len_d < {10'd0, hdr_len_q})) begin
            drop_d = 1'b1;
            code_d = DROP_LENGTH;
          end
        end else if (pos_q == OFS_PROTO) begin
          proto_d = b;
        end else if (pos_q >= OFS_SRC0 && pos_q <= OFS_SRC3) begin
          src_d = {src_q[23:0], b};
        end else if (pos_q >= OFS_DST0 && pos_q <= OFS_DST3) begin
          dst_d = {dst_q[23:0], b};
        end

        if (!pos_q[0]) begin
          hi_byte_d = b;
        end else begin
          csum_d = csum_fold;
        end

        // Last header byte: checksum, then destination
        if (pos_q == {10'd0, hdr_len_d - 6'd1} && !drop_d) begin
          if (csum_d != CSUM_OK) begin
            drop_d = 1'b1;
            code_d = DROP_CHECKSUM;
          end else if (dst_d != local_ip_q) begin
            drop_d = 1'b1;
            code_d = DROP_NOT_OURS;
          end
        end
      end else if (!drop_q && pos_q < total_len_q) begin
        emit             = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = b;
        res.protocol     = proto_q;
        res.source_ip    = src_q;
        res.payload_last = (pos_q == total_len_q - 16'd1);
        res.drop_reason  = DROP_SHORT;
      end

      if (in_data_i.frame_end) begin
        // Frame ended before the header was complete
        if (!drop_d && ({1'b0, pos_q} + 17'd1) < {11'd0, hdr_len_d}) begin
          drop_d = 1'b1;
          code_d = DROP_SHORT;
        end
        if (drop_d && !emit) begin
          emit            = 1'b1;
          res             = '0;
          res.kind        = KIND_DROP;
          res.drop_reason = code_d;
        end
        pos_d       = '0;
        hdr_len_d   = MIN_HDR_BYTES;
        total_len_d = '0;
        csum_d      = '0;
        hi_byte_d   = '0;
        proto_d     = '0;
        src_d       = '0;
        dst_d       = '0;
        drop_d      = 1'b0;
        code_d      = DROP_SHORT;
      end else if (pos_q != POS_MAX) begin
        pos_d = pos_q + 16'd1;
      end
    end
  end

  assign push_o      = emit;
  assign push_data_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= '0;
      pos_q       <= '0;
      hdr_len_q   <= MIN_HDR_BYTES;
      total_len_q <= '0;
      csum_q      <= '0;
      hi_byte_q   <= '0;
      proto_q     <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      drop_q      <= 1'b0;
      code_q      <= DROP_SHORT;
    end else begin
      if (cfg_we_i) begin
        local_ip_q <= cfg_wdata_i;
      end
      pos_q       <= pos_d;
      hdr_len_q   <= hdr_len_d;
      total_len_q <= total_len_d;
      csum_q      <= csum_d;
      hi_byte_q   <= hi_byte_d;
      proto_q     <= proto_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      drop_q      <= drop_d;
      code_q      <= code_d;
    end
  end

endmodule

// ----- src/irf_queue.sv -----
// Short result queue between the front end and the output stage.
module irf_queue
  import irf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  irf_out_t push_data_i,
  input  logic     pop_i,
  output logic     valid_o,
  output irf_out_t data_o,
  output logic     full_o
);

  irf_out_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
    ptr_next = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
  endfunction

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      count_q <= count_d;
    end
  end

endmodule

// ----- src/irf_back.sv -----
// Back end: output register that drains the queue toward the consumer.
module irf_back
  import irf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  irf_out_t q_data_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output irf_out_t out_data_o
);

  logic     valid_q, valid_d;
  irf_out_t data_q;
  logic     load;

  // Register is free when empty or its transaction completes this cycle
  assign load    = ~valid_q | ~out_stall_i;
  assign pop_o   = load & q_valid_i;
  assign valid_d = load ? q_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= q_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- src/ipv4_receive_filter.sv -----
// A byte's result passes through the result queue and the output register to out_valid_o.
// One byte per unstalled cycle; the header checksum add with carry fold is the per-byte path.
// A two-entry result queue and an output register let input and output stall independently.
// Reset (rst_ni low, asynchronous) clears frame state, queue and output valid; local_ip is 0.
// Frame state also returns to its reset values after each frame's last byte.
module ipv4_receive_filter
  import irf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  irf_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output irf_out_t    out_data_o
);

  logic     push;
  irf_out_t push_data;
  logic     q_full;
  logic     q_valid;
  irf_out_t q_data;
  logic     pop;

  irf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  irf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .full_o      (q_full)
  );

  irf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("result pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_drop_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_DROP) |->
      (out_data_o.payload_byte == 8'd0 && out_data_o.source_ip == 32'd0 &&
       out_data_o.protocol == 8'd0 && !out_data_o.payload_last))
    else $error("drop notice carries payload fields");

  a_payload_reason_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_PAYLOAD) |->
      out_data_o.drop_reason == DROP_SHORT)
    else $error("payload transaction carries a drop reason");
`endif

endmodule

// ----- tb/ipv4_receive_filter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the IPv4 receive filter: byte-level predictor and result checker.
module ipv4_receive_filter_tb;
  import irf_pkg::*;

  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 4;
  localparam int TIMEOUT_NS = 1_000_000;
  localparam int MAX_REPORT = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  irf_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  irf_out_t    out_data_o;

  ipv4_receive_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Predicted filter state, mirrors the block's frame state
  logic [31:0]  local_addr = '0;
  logic [15:0]  rx_pos = '0;
  logic [5:0]   hdr_len_exp = 6'd20;
  logic [15:0]  tot_len = '0;
  logic [16:0]  hdr_sum = '0;
  logic [7:0]   hi_byte = '0;
  logic [7:0]   cur_proto = '0;
  logic [31:0]  cur_src = '0;
  logic [31:0]  cur_dst = '0;
  logic         drop_pending = 1'b0;
  drop_reason_e drop_why = DROP_SHORT;

  irf_out_t     pending_results[$];
  logic [7:0]   frame_q[$];

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int mismatches = 0;
  int frames_sent = 0;
  int bytes_sent = 0;
  int payload_seen = 0;
  int drops_seen[6] = '{default: 0};

  function automatic void clear_frame_state();
    rx_pos = '0;
    hdr_len_exp = 6'd20;
    tot_len = '0;
    hdr_sum = '0;
    hi_byte = '0;
    cur_proto = '0;
    cur_src = '0;
    cur_dst = '0;
    drop_pending = 1'b0;
    drop_why = DROP_SHORT;
  endfunction

  // first failing check wins
  function automatic void note_drop(drop_reason_e why);
    if (!drop_pending) begin
      drop_pending = 1'b1;
      drop_why = why;
    end
  endfunction

  function automatic void predict_filter(irf_in_t it);
    irf_out_t    res;
    logic [16:0] s;
    bit          have;
    int          p;
    p = rx_pos;
    have = 1'b0;
    res = '0;
    if (p < hdr_len_exp) begin
      case (p)
        0: begin
          if (it.frame_len < 16'd20) note_drop(DROP_SHORT);
          else if (it.data_byte[7:4] != 4'd4) note_drop(DROP_VERSION);
          else if (it.data_byte[3:0] < 4'd5) note_drop(DROP_HDR_LEN);
          else hdr_len_exp = {it.data_byte[3:0], 2'b00};
        end
        2: tot_len = {it.data_byte, 8'h00};
        3: begin
          tot_len[7:0] = it.data_byte;
          if (tot_len > it.frame_len || tot_len < hdr_len_exp) note_drop(DROP_LENGTH);
        end
        9: cur_proto = it.data_byte;
        12, 13, 14, 15: cur_src = {cur_src[23:0], it.data_byte};
        16, 17, 18, 19: cur_dst = {cur_dst[23:0], it.data_byte};
        default: ;
      endcase
      if (p % 2 == 0) begin
        hi_byte = it.data_byte;
      end else begin
        s = hdr_sum + {hi_byte, it.data_byte};
        if (s > 17'h0FFFF) s = s[15:0] + 17'd1;
        hdr_sum = s;
      end
      if (p == hdr_len_exp - 1 && !drop_pending) begin
        if (hdr_sum[15:0] != 16'hFFFF) note_drop(DROP_CHECKSUM);
        else if (cur_dst != local_addr) note_drop(DROP_NOT_OURS);
      end
    end else if (!drop_pending && p < tot_len) begin
      res.kind = KIND_PAYLOAD;
      res.payload_byte = it.data_byte;
      res.protocol = cur_proto;
      res.source_ip = cur_src;
      res.payload_last = (p == tot_len - 1);
      res.drop_reason = DROP_SHORT;
      have = 1'b1;
    end
    if (it.frame_end) begin
      if (!drop_pending && p + 1 < hdr_len_exp) note_drop(DROP_SHORT);
      if (drop_pending && !have) begin
        res = '0;
        res.kind = KIND_DROP;
        res.drop_reason = drop_why;
        have = 1'b1;
      end
      clear_frame_state();
    end else if (rx_pos != 16'hFFFF) begin
      rx_pos = rx_pos + 16'd1;
    end
    if (have) pending_results.push_back(res);
  endfunction

  // Header with a valid checksum, then payload, then padding past total_len
  function automatic void build_packet(input int words, input int plen, input int pad,
                                       input logic [31:0] dst);
    logic [16:0] acc;
    logic [15:0] tlen;
    int          hdr;
    hdr = words * 4;
    tlen = 16'(hdr + plen);
    frame_q.delete();
    frame_q.push_back({4'd4, 4'(words)});
    frame_q.push_back(8'($urandom));
    frame_q.push_back(tlen[15:8]);
    frame_q.push_back(tlen[7:0]);
    for (int i = 4; i < hdr; i++) frame_q.push_back(8'($urandom));
    frame_q[10] = 8'h00;
    frame_q[11] = 8'h00;
    for (int i = 0; i < 4; i++) frame_q[16 + i] = dst[31 - 8 * i -: 8];
    acc = '0;
    for (int i = 0; i < hdr; i += 2) begin
      acc = acc + {frame_q[i], frame_q[i + 1]};
      if (acc[16]) acc = acc[15:0] + 17'd1;
    end
    frame_q[10] = ~acc[15:8];
    frame_q[11] = ~acc[7:0];
    for (int i = 0; i < plen + pad; i++) frame_q.push_back(8'($urandom));
  endfunction

  task automatic send_byte(input irf_in_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_filter(it);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] flen);
    irf_in_t it;
    for (int i = 0; i < frame_q.size(); i++) begin
      it.data_byte = frame_q[i];
      it.frame_len = flen;
      it.frame_end = (i == frame_q.size() - 1);
      send_byte(it);
    end
    frames_sent++;
  endtask

  task automatic send_single(input logic [7:0] b, input logic [15:0] flen);
    frame_q = '{b};
    send_frame(flen);
  endtask

  task automatic set_total_len(input logic [15:0] tlen);
    frame_q[2] = tlen[15:8];
    frame_q[3] = tlen[7:0];
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // only called with the block drained
  task automatic write_local_ip(input logic [31:0] addr);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    local_addr = addr;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_local_ip();
    build_packet(5, 4, 0, 32'h0000_0000);   // reset address still in effect
    send_frame(16'(frame_q.size()));
    wait_for_drain();
    write_local_ip(32'h0000_0000);
    build_packet(5, 2, 1, 32'hFFFF_FFFF);
    send_frame(16'(frame_q.size()));
    wait_for_drain();
    write_local_ip(32'hFFFF_FFFF);
    build_packet(5, 3, 0, 32'hFFFF_FFFF);
    send_frame(16'(frame_q.size()));
    build_packet(5, 3, 0, 32'h0000_0000);
    send_frame(16'(frame_q.size()));
    wait_for_drain();
    write_local_ip(32'hC0A8_0A01);
  endtask

  task automatic test_first_byte_checks();
    send_single(8'h35, 16'd5);       // short beats bad version
    send_single(8'h45, 16'd0);
    send_single(8'h45, 16'd19);
    send_single(8'hF5, 16'd20);
    send_single(8'h00, 16'hFFFF);    // bad version beats bad IHL
    send_single(8'h44, 16'd20);
    send_single(8'h40, 16'hFFFF);
    send_single(8'h45, 16'd20);      // ends before the header is complete
    frame_q = '{8'h4F, 8'h00};
    send_frame(16'd60);
    wait_for_drain();
  endtask

  task automatic test_total_len_checks();
    build_packet(5, 10, 0, local_addr);
    set_total_len(16'd31);           // beyond frame, checksum also broken
    send_frame(16'd30);
    build_packet(5, 10, 0, local_addr);
    set_total_len(16'd19);
    send_frame(16'd30);
    build_packet(6, 10, 0, local_addr);
    set_total_len(16'd22);           // below a 24-byte header
    send_frame(16'd34);
    build_packet(5, 10, 0, local_addr);
    set_total_len(16'd0);
    while (frame_q.size() > 4) frame_q.pop_back();
    send_frame(16'd30);
    wait_for_drain();
  endtask

  task automatic test_header_accept();
    build_packet(5, 6, 0, local_addr);
    frame_q[11] = frame_q[11] ^ 8'h01;
    send_frame(16'(frame_q.size()));
    build_packet(5, 6, 0, local_addr ^ 32'h8000_0000);
    send_frame(16'(frame_q.size()));
    build_packet(5, 6, 0, 32'h1234_5678);
    frame_q[12] = frame_q[12] ^ 8'h10;  // checksum wins over wrong destination
    send_frame(16'(frame_q.size()));
    build_packet(5, 0, 0, local_addr);  // header only, nothing comes out
    send_frame(16'(frame_q.size()));
    build_packet(15, 3, 2, local_addr); // full options plus padding
    send_frame(16'(frame_q.size()));
    build_packet(5, 1, 0, local_addr);
    send_frame(16'(frame_q.size()));
    build_packet(5, 10, 0, local_addr);
    while (frame_q.size() > 25) frame_q.pop_back();   // ends inside payload
    send_frame(16'd30);
    build_packet(5, 10, 0, local_addr);
    while (frame_q.size() > 20) frame_q.pop_back();   // ends on last header byte
    send_frame(16'd30);
    build_packet(5, 10, 0, local_addr);
    while (frame_q.size() > 12) frame_q.pop_back();
    send_frame(16'd30);
    wait_for_drain();
  endtask

  // total_len at its maximum, frame cut short inside the payload
  task automatic test_long_frame();
    idle_on = 1'b0;
    build_packet(5, 65515, 5, local_addr);
    while (frame_q.size() > 60) frame_q.pop_back();
    send_frame(16'hFFFF);
    wait_for_drain();
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (3) begin
      build_packet(5, 30, 2, local_addr);
      send_frame(16'(frame_q.size()));
    end
    wait_for_drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int byte_budget);
    int          start_bytes;
    int          sel;
    int          words;
    int          v;
    int          idx;
    logic [15:0] flen;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < byte_budget) begin
      sel = $urandom_range(0, 99);
      words = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
      build_packet(words, $urandom_range(0, 24),
                   ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0,
                   (sel >= 60 && sel < 67) ? local_addr ^ (32'h1 << $urandom_range(0, 31))
                                           : local_addr);
      flen = 16'(frame_q.size());
      if (sel >= 67 && sel < 72) begin
        v = $urandom_range(0, 14);
        if (v >= 4) v++;
        frame_q[0][7:4] = 4'(v);
      end else if (sel >= 72 && sel < 76) begin
        frame_q[0][3:0] = 4'($urandom_range(0, 4));
      end else if (sel >= 76 && sel < 80) begin
        set_total_len(flen + 16'($urandom_range(1, 64)));
      end else if (sel >= 80 && sel < 83) begin
        set_total_len(16'($urandom_range(0, words * 4 - 1)));
      end else if (sel >= 83 && sel < 88) begin
        idx = $urandom_range(4, words * 4 - 1);
        frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(0, 7));
      end else if (sel >= 88 && sel < 94) begin
        idx = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > idx) frame_q.pop_back();
      end else if (sel >= 94) begin
        frame_q.delete();
        repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
        flen = 16'($urandom);
      end
      send_frame(flen);
    end
    wait_for_drain();
  endtask

  task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORT)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    irf_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("%0t: unexpected transaction: expected none, actual %h", $time, out_data_o);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data_o.kind));
        check_field("payload_byte", 32'(want.payload_byte), 32'(out_data_o.payload_byte));
        check_field("protocol", 32'(want.protocol), 32'(out_data_o.protocol));
        check_field("source_ip", want.source_ip, out_data_o.source_ip);
        check_field("payload_last", 32'(want.payload_last), 32'(out_data_o.payload_last));
        check_field("drop_reason", 32'(want.drop_reason), 32'(out_data_o.drop_reason));
        if (want.kind == KIND_PAYLOAD) payload_seen++;
        else drops_seen[int'(want.drop_reason)]++;
      end
    end
  end

  // Receiver side: random stall bursts, or one long hold on request
  initial begin : rx_side
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_local_ip();
    test_first_byte_checks();
    test_total_len_checks();
    test_header_accept();
    test_backpressure();
    test_long_frame();
    write_local_ip($urandom);
    test_random_traffic(200);
    write_local_ip(32'hFFFF_FFFF);
    test_random_traffic(200);
    idle_on = 1'b0;
    write_local_ip(32'h0000_0000);
    test_random_traffic(150);
    $display("Sent %0d frames (%0d bytes); checked %0d payload bytes.",
             frames_sent, bytes_sent, payload_seen);
    $display("Drop notices short/version/length/ihl/checksum/not-ours: %0d %0d %0d %0d %0d %0d",
             drops_seen[0], drops_seen[1], drops_seen[2], drops_seen[3], drops_seen[4],
             drops_seen[5]);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
src/irf_pkg.sv
src/irf_front.sv
src/irf_queue.sv
src/irf_back.sv
src/ipv4_receive_filter.sv
tb/ipv4_receive_filter_tb.sv
